### design/led_blink_queue_sequencer_defines.svh
// Assertion macros for the LED blink queue sequencer.
`ifndef LED_BLINK_QUEUE_SEQUENCER_DEFINES_SVH
`define LED_BLINK_QUEUE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LBQS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbqs assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LBQS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbqs assertion failed");

`endif

### design/lbqs_pkg.sv
// Shared types and codes for the LED blink queue sequencer.
`timescale 1ns / 1ps

package lbqs_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ENQ  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LIT  = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] on_time;
		logic [15:0] gap_time;
	} entry_t;

endpackage

### design/lbqs_ring.sv
// Blink ring storage: one write port, one registered read port.
`timescale 1ns / 1ps

module lbqs_ring #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  lbqs_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output lbqs_pkg::entry_t rd_data
);

	lbqs_pkg::entry_t mem [DEPTH];
	lbqs_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/led_blink_queue_sequencer.sv
// Top level of the LED blink queue sequencer.
//
// Usage:
//   A transaction is offered on op/on_time/gap_time with start; it is taken at
//   a rising edge where start is high and busy is low. op = enqueue stores an
//   on-time/gap-time pair at the tail of the ring (refused with dropped = 1
//   when all QUEUE_DEPTH slots are in use). op = tick advances the blink
//   player by one millisecond.
//   Every transaction yields exactly one result on led/phase/queued/busy_res/
//   dropped, marked by done for a single cycle. The receiver cannot stall;
//   the result must be taken in that cycle.
//   Timing: an enqueue, or a tick while the player is idle, gives its result
//   in the cycle after acceptance. A tick while the LED is lit or in its gap
//   reads the head pair from the ring memory through its registered read port,
//   then finishes in S_EXEC before its result is registered; busy stays high in
//   between. Enqueues and idle ticks can be taken one transaction per cycle;
//   a timing tick holds busy high until its result, set by the ring read port.
//   Reset (arst_n low) empties the ring, parks the player idle with elapsed
//   time cleared and drops any pending result. Ring contents are not cleared;
//   only slots within the count are ever read.
`timescale 1ns / 1ps
`include "led_blink_queue_sequencer_defines.svh"

module led_blink_queue_sequencer #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] on_time,
	input  logic [15:0] gap_time,
	output logic        done,
	output logic        led,
	output logic [1:0]  phase,
	output logic [3:0]  queued,
	output logic        busy_res,
	output logic        dropped
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		S_READY,
		S_EXEC
	} fsm_t;

	fsm_t                 state_q, state_d;
	lbqs_pkg::phase_t     phase_q, phase_d;
	logic [IDX_W-1:0]     head_q, head_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [15:0]          elapsed_q, elapsed_d;

	logic                 done_q;
	logic                 led_q;
	logic [1:0]           phase_out_q;
	logic [3:0]           queued_q;
	logic                 busy_res_q;
	logic                 dropped_q;

	logic                 accept;
	logic                 tick_timed;
	logic                 fire;
	logic                 drop;
	logic                 full;
	logic                 wr_en;
	logic                 rd_en;
	logic [IDX_W:0]       slot_sum;
	logic [IDX_W-1:0]     slot;
	logic [15:0]          bump;
	lbqs_pkg::entry_t     wr_data;
	lbqs_pkg::entry_t     rd_data;

	assign accept = start && !busy;
	assign busy   = (state_q == S_EXEC);
	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));

	// A tick that has to look at the head pair: the LED is lit or in its gap.
	assign tick_timed = (op == lbqs_pkg::OP_TICK) &&
		(phase_q == lbqs_pkg::PH_LIT || phase_q == lbqs_pkg::PH_GAP);

	// Tail slot: head plus count, wrapped once. Only used when not full, so
	// the count fits in the index width.
	assign slot_sum = {1'b0, head_q} + (IDX_W + 1)'(cnt_q[IDX_W-1:0]);
	assign slot     = (slot_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
		? IDX_W'(slot_sum - (IDX_W + 1)'(QUEUE_DEPTH))
		: slot_sum[IDX_W-1:0];

	assign wr_data.on_time  = on_time;
	assign wr_data.gap_time = gap_time;

	// Saturating millisecond count.
	assign bump = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	lbqs_ring #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		elapsed_d = elapsed_q;
		fire      = 1'b0;
		drop      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		unique case (state_q)
			S_READY: begin
				if (accept) begin
					if (op == lbqs_pkg::OP_ENQ) begin
						// enqueue: store at the tail or refuse when full
						fire = 1'b1;
						if (full) begin
							drop = 1'b1;
						end else begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CNT_W'(1);
						end
					end else if (tick_timed) begin
						// timing tick: fetch the head pair, finish next cycle
						rd_en   = 1'b1;
						state_d = S_EXEC;
					end else begin
						// idle tick: light the LED if anything is queued
						fire    = 1'b1;
						phase_d = lbqs_pkg::PH_IDLE;
						if (cnt_q != '0) begin
							phase_d   = lbqs_pkg::PH_LIT;
							elapsed_d = '0;
						end
					end
				end
			end
			S_EXEC: begin
				fire    = 1'b1;
				state_d = S_READY;
				unique case (phase_q)
					lbqs_pkg::PH_LIT: begin
						elapsed_d = bump;
						if (bump >= rd_data.on_time) begin
							phase_d   = lbqs_pkg::PH_GAP;
							elapsed_d = '0;
						end
					end
					lbqs_pkg::PH_GAP: begin
						elapsed_d = bump;
						if (bump >= rd_data.gap_time) begin
							// retire the head blink
							if (cnt_q != '0) begin
								cnt_d = cnt_q - CNT_W'(1);
							end
							head_d    = (head_q == IDX_W'(QUEUE_DEPTH - 1))
								? '0 : head_q + IDX_W'(1);
							phase_d   = lbqs_pkg::PH_IDLE;
							elapsed_d = '0;
						end
					end
					default: begin
						phase_d = lbqs_pkg::PH_IDLE;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_READY;
			phase_q     <= lbqs_pkg::PH_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			elapsed_q   <= '0;
			done_q      <= 1'b0;
			led_q       <= 1'b0;
			phase_out_q <= '0;
			queued_q    <= '0;
			busy_res_q  <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			head_q    <= head_d;
			cnt_q     <= cnt_d;
			elapsed_q <= elapsed_d;
			done_q    <= fire;
			if (fire) begin
				led_q       <= (phase_d == lbqs_pkg::PH_LIT);
				phase_out_q <= phase_d;
				queued_q    <= 4'(cnt_d);
				busy_res_q  <= (cnt_d != '0) || (phase_d != lbqs_pkg::PH_IDLE);
				dropped_q   <= drop;
			end
		end
	end

	assign done     = done_q;
	assign led      = led_q;
	assign phase    = phase_out_q;
	assign queued   = queued_q;
	assign busy_res = busy_res_q;
	assign dropped  = dropped_q;

	// count never exceeds the ring size
	`LBQS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH))
	// a timing tick waits for the ring read before its result
	`LBQS_ASSERT_NEXT(a_tick_waits, accept && tick_timed, busy && !done)
	// the read-modify step always completes in the following cycle
	`LBQS_ASSERT_NEXT(a_exec_done, state_q == S_EXEC, done && !busy)
	// a refused enqueue only happens with a full ring
	`LBQS_ASSERT_NOW(a_drop_full, done && dropped, full && (phase_q == $past(phase_q)))

endmodule
